/* rtl/scalar_to_false_color_assert.svh */
// Assertion macros for the false colour block checker.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef SCALAR_TO_FALSE_COLOR_ASSERT_SVH
`define SCALAR_TO_FALSE_COLOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define STC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define STC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stc_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the false colour block.
// No dependencies.
`default_nettype none

package stc_pkg;

    localparam logic [1:0] REG_LEVELS = 2'd0;
    localparam logic [1:0] REG_UPPER  = 2'd1;
    localparam logic [1:0] REG_LOWER  = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    // Phase scale: 2**PHASE_SHIFT is a full turn of 2*pi
    localparam int          PHASE_SHIFT = 14;
    localparam int          PHASE_W     = 14;
    localparam logic [13:0] PHASE_PI    = 14'd8192;
    localparam logic [13:0] PHASE_HALF  = 14'd4096;

    localparam logic [16:0] TRIG_ONE = 17'd65536;

    typedef enum logic [1:0] {
        KIND_FIX,
        KIND_NEG,
        KIND_POS
    } kind_t;

    function automatic logic [16:0] quarter_sine(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/stc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
// Uses no package items.
`default_nettype none

module stc_div #(
    parameter int NL = 1,
    parameter int NW = 42,
    parameter int DW = 33,
    parameter int QW = 9
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [NL-1:0][NW-1:0]  in_dividend,
    input  wire logic [DW-1:0]          in_divisor,
    output logic                        out_valid,
    output logic      [NL-1:0][QW-1:0]  out_quot
);

    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic                  valid_reg [QW];
    logic [NL-1:0][NW-1:0] rem_reg   [QW];
    logic [NL-1:0][QW-1:0] quot_reg  [QW];
    logic [DW-1:0]         den_reg   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;

        logic                  v_in;
        logic [NL-1:0][NW-1:0] r_in;
        logic [NL-1:0][QW-1:0] q_in;
        logic [DW-1:0]         d_in;
        logic [XW-1:0]         shifted;
        logic [NL-1:0][NW-1:0] rem_next;
        logic [NL-1:0][QW-1:0] quot_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_dividend;
            assign q_in = '0;
            assign d_in = in_divisor;
        end else begin : g_rest
            assign v_in = valid_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = quot_reg[j-1];
            assign d_in = den_reg[j-1];
        end

        assign shifted = XW'(d_in) << B;

        always_comb
        begin
            for (int n = 0; n < NL; n++)
            begin
                // take the bit when the shifted divisor still fits
                if (XW'(r_in[n]) >= shifted)
                begin
                    rem_next[n]  = r_in[n] - NW'(shifted);
                    quot_next[n] = q_in[n] | (QW'(1) << B);
                end
                else
                begin
                    rem_next[n]  = r_in[n];
                    quot_next[n] = q_in[n];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                quot_reg[j] <= quot_next;
                den_reg[j]  <= d_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];

endmodule

`default_nettype wire

/* rtl/stc_front.sv */
// Front end: limit checks, normalising product and dividend set-up for the level divider.
// Depends on stc_pkg (kind_t).
`default_nettype none

module stc_front #(
    parameter int SW = 32,
    parameter int LW = 9
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [SW-1:0] sample,
    input  wire logic signed [SW-1:0] upper,
    input  wire logic signed [SW-1:0] lower,
    input  wire logic        [LW-1:0] levels,
    output logic                      out_valid,
    output logic        [LW+SW:0]     out_dividend,
    output logic        [SW:0]        out_divisor
);

    localparam int NW = LW + SW + 1;

    logic [SW-1:0]        mag_s;
    logic [SW-1:0]        mag_l;
    stc_pkg::kind_t       kind_next;
    logic [SW:0]          diff_next;
    logic [SW:0]          den_next;
    logic [LW:0]          mid_level;

    logic                 valid1_reg;
    stc_pkg::kind_t       kind1_reg;
    logic [SW:0]          diff1_reg;
    logic [SW:0]          den1_reg;

    logic [NW-1:0]        num_next;
    logic                 valid2_reg;
    stc_pkg::kind_t       kind2_reg;
    logic [NW-1:0]        num2_reg;
    logic [SW:0]          den2_reg;

    logic [NW-1:0]        dividend_next;
    logic                 valid3_reg;
    logic [NW-1:0]        dividend3_reg;
    logic [SW:0]          den3_reg;

    assign mid_level = ((LW+1)'(levels) + (LW+1)'(1)) >> 1;

    // Stage 1: classify. Fixed levels pass through the divider as level / 1.
    always_comb
    begin
        mag_s = sample[SW-1] ? (~sample + 1'b1) : sample;
        mag_l = lower[SW-1] ? (~lower + 1'b1) : lower;
        priority if (sample > upper)
        begin
            kind_next = stc_pkg::KIND_FIX;
            diff_next = (SW+1)'(levels);
            den_next  = (SW+1)'(1);
        end
        else if (sample < lower)
        begin
            kind_next = stc_pkg::KIND_FIX;
            diff_next = '0;
            den_next  = (SW+1)'(1);
        end
        else if (sample == '0)
        begin
            kind_next = stc_pkg::KIND_FIX;
            diff_next = (SW+1)'(mid_level);
            den_next  = (SW+1)'(1);
        end
        else if (sample[SW-1])
        begin
            kind_next = stc_pkg::KIND_NEG;
            diff_next = {1'b0, mag_l - mag_s};
            den_next  = {mag_l, 1'b0};
        end
        else
        begin
            kind_next = stc_pkg::KIND_POS;
            diff_next = {1'b0, upper} + {1'b0, sample};
            den_next  = {upper, 1'b0};
        end
    end

    // Stage 2: scale the distance by the level count; fixed levels pass unscaled
    assign num_next = (kind1_reg == stc_pkg::KIND_FIX) ? NW'(diff1_reg)
                                                        : NW'(levels) * NW'(diff1_reg);

    // Stage 3: round down below the midpoint, up above it
    always_comb
    begin
        unique case (kind2_reg)
            stc_pkg::KIND_NEG: dividend_next = (num2_reg == '0) ? '0 : num2_reg - NW'(1);
            stc_pkg::KIND_POS: dividend_next = num2_reg + NW'(den2_reg) - NW'(1);
            default:           dividend_next = num2_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg     <= kind_next;
            diff1_reg     <= diff_next;
            den1_reg      <= den_next;
            kind2_reg     <= kind1_reg;
            num2_reg      <= num_next;
            den2_reg      <= den1_reg;
            dividend3_reg <= dividend_next;
            den3_reg      <= den2_reg;
        end
    end

    assign out_valid    = valid3_reg;
    assign out_dividend = dividend3_reg;
    assign out_divisor  = den3_reg;

endmodule

`default_nettype wire

/* rtl/stc_trig.sv */
// Back end: elliptic palette from the sine table, selection against the bilinear ramp.
// Depends on stc_pkg (phase constants, quarter_sine).
`default_nettype none

module stc_trig #(
    parameter int CW  = 16,
    parameter int QW2 = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  elliptic,
    input  wire logic                  in_valid,
    input  wire logic [2:0][QW2-1:0]   in_quot,
    output logic                       out_valid,
    output logic      [CW-1:0]         red,
    output logic      [CW-1:0]         green,
    output logic      [CW-1:0]         blue
);

    localparam logic [CW-1:0] CFULL = '1;

    logic [13:0]    phase;
    logic           cneg_next;
    logic [12:0]    sarg_next;
    logic [12:0]    carg_next;

    logic           valid1_reg;
    logic           cneg1_reg;
    logic [12:0]    sarg1_reg;
    logic [12:0]    carg1_reg;
    logic [CW-1:0]  bil_r1_reg;
    logic [CW-1:0]  bil_g1_reg;
    logic [CW-1:0]  bil_b1_reg;

    logic           valid2_reg;
    logic           cneg2_reg;
    logic [16:0]    sin2_reg;
    logic [16:0]    cos2_reg;
    logic [CW-1:0]  bil_r2_reg;
    logic [CW-1:0]  bil_g2_reg;
    logic [CW-1:0]  bil_b2_reg;

    logic [17:0]    q_red;
    logic [17:0]    q_blue;
    logic [17:0]    q_green;
    logic           valid3_reg;
    logic [CW-1:0]  red3_reg;
    logic [CW-1:0]  green3_reg;
    logic [CW-1:0]  blue3_reg;

    // sine over a quarter wave, 4096 is pi/2, interpolated over 256 sub-steps
    function automatic logic [16:0] qsin(input logic [12:0] d);
        logic [16:0] lo_v;
        logic [16:0] hi_v;
        logic [24:0] prod;
        lo_v = stc_pkg::quarter_sine({1'b0, d[11:8]});
        hi_v = stc_pkg::quarter_sine({1'b0, d[11:8]} + 5'd1);
        prod = 25'(hi_v - lo_v) * 25'(d[7:0]) + 25'd128;
        return d[12] ? stc_pkg::TRIG_ONE : lo_v + 17'(prod >> 8);
    endfunction

    // Q17 fraction to channel scale, round half up
    function automatic logic [CW-1:0] to_color(input logic [17:0] q);
        logic [CW+17:0] prod;
        prod = (CW+18)'(q) * (CW+18)'(CFULL) + (CW+18)'(stc_pkg::TRIG_ONE);
        return CW'(prod >> 17);
    endfunction

    // Stage 1: fold the phase into sine and cosine quarter-wave arguments
    always_comb
    begin
        phase     = (in_quot[0] > QW2'(stc_pkg::PHASE_PI)) ? stc_pkg::PHASE_PI
                                                          : in_quot[0][13:0];
        cneg_next = phase > stc_pkg::PHASE_HALF;
        sarg_next = cneg_next ? 13'(stc_pkg::PHASE_PI - phase) : 13'(phase);
        carg_next = cneg_next ? 13'(phase - stc_pkg::PHASE_HALF)
                              : 13'(stc_pkg::PHASE_HALF - phase);
    end

    // Stage 3 operands
    assign q_red   = cneg2_reg ? 18'(stc_pkg::TRIG_ONE) + 18'(cos2_reg)
                               : 18'(stc_pkg::TRIG_ONE) - 18'(cos2_reg);
    assign q_blue  = cneg2_reg ? 18'(stc_pkg::TRIG_ONE) - 18'(cos2_reg)
                               : 18'(stc_pkg::TRIG_ONE) + 18'(cos2_reg);
    assign q_green = {sin2_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cneg1_reg  <= cneg_next;
            sarg1_reg  <= sarg_next;
            carg1_reg  <= carg_next;
            bil_g1_reg <= in_quot[0][CW-1:0];
            bil_r1_reg <= in_quot[1][CW-1:0];
            bil_b1_reg <= in_quot[2][CW-1:0];

            cneg2_reg  <= cneg1_reg;
            sin2_reg   <= qsin(sarg1_reg);
            cos2_reg   <= qsin(carg1_reg);
            bil_r2_reg <= bil_r1_reg;
            bil_g2_reg <= bil_g1_reg;
            bil_b2_reg <= bil_b1_reg;

            red3_reg   <= elliptic ? to_color(q_red)   : bil_r2_reg;
            green3_reg <= elliptic ? to_color(q_green) : bil_g2_reg;
            blue3_reg  <= elliptic ? to_color(q_blue)  : bil_b2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign red       = red3_reg;
    assign green     = green3_reg;
    assign blue      = blue3_reg;

endmodule

`default_nettype wire

/* rtl/scalar_to_false_color.sv */
// Scalar to false colour converter: top level with configuration registers.
// Depends on stc_pkg, stc_front, stc_div and stc_trig.
//
// Usage:
//   Input beats on s_axis_* carry one signed Q15.16 sample each; output beats on
//   m_axis_* carry one RGB colour, 16 bits a channel, 65535 standing for 1.0.
//   Registers are written through cfg_we / cfg_index / cfg_data, one write per
//   clock with cfg_we high; the user must write only while no beat is in flight,
//   the block does not enforce this. Throughput: one beat per clock while
//   the output is not stalled. Beats pass through the front end, two
//   bit-per-stage dividers (one finds the palette level, one lane group works
//   out the colour ramp or the sine phase from it) and the trig unit.
//   Stalls: the whole pipeline advances together whenever the output register
//   is empty or being taken; s_axis_tready follows that, so while the receiver
//   holds m_axis_tready low with a beat waiting, nothing moves and nothing drops.
//   Reset: all valid bits clear, the registers return to 16 levels, limits
//   +1.0 / -1.0 and the bilinear palette.
`default_nettype none

module scalar_to_false_color #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COLOR_WIDTH  = 16,
    parameter int MAX_LEVELS   = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration write port
    input  wire logic                                   cfg_we,
    input  wire logic [1:0]                             cfg_index,
    input  wire logic [SAMPLE_WIDTH-1:0]                cfg_data,
    // input stream
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata: sample_value
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // output stream
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata: red_level, green_level, blue_level
    output logic      [((3*COLOR_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COLOR_WIDTH;
    localparam int LW     = $clog2(MAX_LEVELS + 1);
    localparam int NW_K   = LW + SW + 1;
    localparam int DW_K   = SW + 1;
    localparam int QW2    = (CW > stc_pkg::PHASE_W) ? CW : stc_pkg::PHASE_W;
    localparam int RW_BIL = LW + CW + 2;
    localparam int RW_ELL = LW + stc_pkg::PHASE_SHIFT + 1;
    localparam int RW     = (RW_BIL > RW_ELL) ? RW_BIL : RW_ELL;
    localparam int OUT_TDATA_W = ((3*CW+7)/8)*8;

    localparam logic [CW-1:0] CFULL    = '1;
    localparam logic [CW:0]   TWO_FULL = {CFULL, 1'b0};

    logic [8:0]           levels_reg;
    logic signed [SW-1:0] upper_reg;
    logic signed [SW-1:0] lower_reg;
    logic                 elliptic_reg;

    logic [LW-1:0]        levels_eff;
    logic                 en;

    logic                 front_valid;
    logic [NW_K-1:0]      front_dividend;
    logic [DW_K-1:0]      front_divisor;

    logic                 k_valid;
    logic [0:0][LW-1:0]   k_quot;

    logic [LW:0]          twok;
    logic [LW:0]          twol;
    logic                 low_half;
    logic [LW:0]          a_green;
    logic [LW:0]          a_red;
    logic [LW:0]          a_blue;
    logic [2:0][RW-1:0]   prep_next;

    logic                 prep_valid_reg;
    logic [2:0][RW-1:0]   prep_div_reg;
    logic [LW:0]          prep_den_reg;

    logic                 ramp_valid;
    logic [2:0][QW2-1:0]  ramp_quot;

    logic [CW-1:0]        red;
    logic [CW-1:0]        green;
    logic [CW-1:0]        blue;

    // advance everything together while the output register can move
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg   <= 9'd16;
            upper_reg    <= SW'(65536);
            lower_reg    <= SW'(-65536);
            elliptic_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stc_pkg::REG_LEVELS: levels_reg   <= cfg_data[8:0];
                stc_pkg::REG_UPPER:  upper_reg    <= cfg_data;
                stc_pkg::REG_LOWER:  lower_reg    <= cfg_data;
                stc_pkg::REG_MODE:   elliptic_reg <= cfg_data[0];
            endcase
        end
    end

    // Treat zero levels as one, clip the count at MAX_LEVELS
    always_comb
    begin
        priority if (levels_reg == 9'd0)
        begin
            levels_eff = LW'(1);
        end
        else if (32'(levels_reg) > MAX_LEVELS)
        begin
            levels_eff = LW'(MAX_LEVELS);
        end
        else
        begin
            levels_eff = LW'(levels_reg);
        end
    end

    stc_front #(
        .SW (SW),
        .LW (LW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .sample       (s_axis_tdata[SW-1:0]),
        .upper        (upper_reg),
        .lower        (lower_reg),
        .levels       (levels_eff),
        .out_valid    (front_valid),
        .out_dividend (front_dividend),
        .out_divisor  (front_divisor)
    );

    // Palette level k, one bit per stage
    stc_div #(
        .NL (1),
        .NW (NW_K),
        .DW (DW_K),
        .QW (LW)
    ) u_level_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (front_valid),
        .in_dividend (front_dividend),
        .in_divisor  (front_divisor),
        .out_valid   (k_valid),
        .out_quot    (k_quot)
    );

    // Ramp set-up. Bilinear: lane 0 green, lane 1 red, lane 2 blue, each the
    // rounded a*CFULL/L; a channel at zero gets a dividend of L, quotient zero.
    // Elliptic: lane 0 carries the phase k*16384/(2L), rounded.
    always_comb
    begin
        twok     = {k_quot[0], 1'b0};
        twol     = {levels_eff, 1'b0};
        low_half = twok <= (LW+1)'(levels_eff);
        a_green  = low_half ? twok : twol - twok;
        a_red    = low_half ? '0 : twok - (LW+1)'(levels_eff);
        a_blue   = low_half ? (LW+1)'(levels_eff) - twok : '0;
        if (elliptic_reg)
        begin
            prep_next[0] = (RW'(k_quot[0]) << stc_pkg::PHASE_SHIFT) + RW'(levels_eff);
            prep_next[1] = '0;
            prep_next[2] = '0;
        end
        else
        begin
            prep_next[0] = RW'(a_green) * RW'(TWO_FULL) + RW'(levels_eff);
            prep_next[1] = RW'(a_red)   * RW'(TWO_FULL) + RW'(levels_eff);
            prep_next[2] = RW'(a_blue)  * RW'(TWO_FULL) + RW'(levels_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= k_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_div_reg <= prep_next;
            prep_den_reg <= twol;
        end
    end

    stc_div #(
        .NL (3),
        .NW (RW),
        .DW (LW + 1),
        .QW (QW2)
    ) u_ramp_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (prep_valid_reg),
        .in_dividend (prep_div_reg),
        .in_divisor  (prep_den_reg),
        .out_valid   (ramp_valid),
        .out_quot    (ramp_quot)
    );

    // Last stage of the trig unit doubles as the output register
    stc_trig #(
        .CW  (CW),
        .QW2 (QW2)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .elliptic  (elliptic_reg),
        .in_valid  (ramp_valid),
        .in_quot   (ramp_quot),
        .out_valid (m_axis_tvalid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_axis_tdata = OUT_TDATA_W'({blue, green, red});

endmodule

`default_nettype wire

/* rtl/stc_checker.sv */
// Port-level checker for the false colour block, bound to the top level.
// Depends on scalar_to_false_color_assert.svh.
`default_nettype none

`include "scalar_to_false_color_assert.svh"

module stc_checker #(
    parameter int DW = 48
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_axis_tvalid,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [DW-1:0] m_axis_tdata
);

    `STC_ASSERT_SAME(a_ready_follows_output, s_axis_tvalid || !s_axis_tvalid, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output state")

    `STC_ASSERT_NEXT(a_stalled_beat_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

    `STC_ASSERT_NEXT(a_stall_closes_input, m_axis_tvalid && !m_axis_tready && !m_axis_tready, !s_axis_tready || m_axis_tready, "input open while output stalled")

endmodule

bind scalar_to_false_color stc_checker #(
    .DW (OUT_TDATA_W)
) u_stc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/sv/scalar_to_false_color_tb.sv */
// Testbench for scalar_to_false_color: directed table then random samples,
// each colour beat checked against a typed-in value or a behavioural colour predictor.
// Depends on stc_pkg and the scalar_to_false_color RTL.
`timescale 1ns / 1ps

module scalar_to_false_color_tb;

    localparam int LATENCY   = 32;
    localparam int N_RANDOM  = 1650;
    localparam int CYC_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    // Predictor's copy of the registers
    logic [8:0]  levels_q;
    logic [31:0] upper_q;
    logic [31:0] lower_q;
    logic        ellip_q;

    logic [47:0] colour_queue[$];
    int          errors;
    int          n_checked;
    int          cycles;
    bit          calm;   // no idling while set

    scalar_to_false_color u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Quarter-wave sine, 4096 = pi/2, Q16 out, linear interpolation
    function automatic longint unsigned qsine(input longint unsigned d);
        longint unsigned lo, hi;
        if (d >= 4096)
            return 65536;
        lo = stc_pkg::quarter_sine(d[12:8]);
        hi = stc_pkg::quarter_sine(d[12:8] + 5'd1);
        return lo + (((hi - lo) * (d & 255) + 128) >> 8);
    endfunction

    function automatic longint unsigned ramp_level(input longint unsigned a,
                                                   input longint unsigned l);
        return (2 * a * 65535 + l) / (2 * l);
    endfunction

    function automatic longint unsigned q17_level(input longint unsigned q);
        return (q * 65535 + 65536) >> 17;
    endfunction

    // Work out the colour beat for one sample under the current registers
    function automatic logic [47:0] false_colour(input logic signed [31:0] s);
        longint unsigned l, k, num, den, ml, p, sn, cm, r, g, b;
        longint signed   sv, up, lo;
        sv = s;
        up = $signed(upper_q);
        lo = $signed(lower_q);
        l = levels_q;
        if (l == 0) l = 1;
        if (l > 256) l = 256;
        if (sv > up)
            k = l;
        else if (sv < lo)
            k = 0;
        else if (sv == 0)
            k = (l + 1) / 2;
        else if (sv < 0)
        begin
            ml  = -lo;
            num = l * (ml - longint'(-sv));
            den = 2 * ml;
            k   = (num == 0) ? 0 : (num - 1) / den;
        end
        else
        begin
            num = l * (up + sv);
            den = 2 * up;
            k   = (num + den - 1) / den;
        end
        if (ellip_q)
        begin
            p = (k * 16384 + l) / (2 * l);
            if (p > 8192) p = 8192;
            sn = qsine(p > 4096 ? 8192 - p : p);
            cm = qsine(p > 4096 ? p - 4096 : 4096 - p);
            r  = q17_level(p > 4096 ? 65536 + cm : 65536 - cm);
            b  = q17_level(p > 4096 ? 65536 - cm : 65536 + cm);
            g  = q17_level(2 * sn);
        end
        else if (2 * k <= l)
        begin
            r = 0;
            g = ramp_level(2 * k, l);
            b = ramp_level(l - 2 * k, l);
        end
        else
        begin
            r = ramp_level(2 * k - l, l);
            g = ramp_level(2 * l - 2 * k, l);
            b = 0;
        end
        return {b[15:0], g[15:0], r[15:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        errors++;
        $display("mismatch %s: got r=%0d g=%0d b=%0d want r=%0d g=%0d b=%0d", what,
                 got[15:0], got[31:16], got[47:32], want[15:0], want[31:16], want[47:32]);
    endtask

    // Receiver: random back-pressure, compare each colour beat with the oldest
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (colour_queue.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, 48'd0);
                else
                begin
                    logic [47:0] want;
                    want = colour_queue.pop_front();
                    if (m_axis_tdata[15:0] !== want[15:0])
                        report_mismatch("red", m_axis_tdata, want);
                    else if (m_axis_tdata[31:16] !== want[31:16])
                        report_mismatch("green", m_axis_tdata, want);
                    else if (m_axis_tdata[47:32] !== want[47:32])
                        report_mismatch("blue", m_axis_tdata, want);
                    n_checked++;
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    initial
    begin
        wait (cycles > CYC_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
    end

    // One register write, then a pause with cfg_we low so writes never share a time step
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            stc_pkg::REG_LEVELS: levels_q = val[8:0];
            stc_pkg::REG_UPPER:  upper_q  = val;
            stc_pkg::REG_LOWER:  lower_q  = val;
            default:             ellip_q  = val[0];
        endcase
        @(posedge clk);
    endtask

    // Drain the pipe before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (colour_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Present one sample and hold until the beat is taken; idle gaps first
    task automatic send_sample(input logic [31:0] s, input logic [47:0] want);
        while (!calm && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        colour_queue.push_back(want);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(131072) - 65536;
            2: return $signed(upper_q) + $urandom_range(2) - 1;
            3: return $signed(lower_q) + $urandom_range(2) - 1;
            default:
            begin
                longint signed lo, hi;
                lo = $signed(lower_q);
                hi = $signed(upper_q);
                if (hi <= lo) return $urandom;
                return lo + ((longint'($urandom) << 16 ^ $urandom) % (hi - lo + 1));
            end
        endcase
    endfunction

    typedef struct {
        logic [31:0] sample;
        bit          typed;
        logic [47:0] colour;
    } stim_row_t;

    stim_row_t directed[$];
    int        phase;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = stc_pkg::REG_LEVELS; cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0; n_checked = 0; cycles = 0; calm = 1'b0;
        levels_q = 9'd16; upper_q = 32'sd65536; lower_q = -32'sd65536; ellip_q = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, top/bottom/zero colours typed in, rest predicted
        directed.push_back('{32'h7FFF_FFFF, 1'b1, {16'd0, 16'd0, 16'd65535}});
        directed.push_back('{32'h8000_0000, 1'b1, {16'd65535, 16'd0, 16'd0}});
        directed.push_back('{32'd0, 1'b1, {16'd0, 16'd65535, 16'd0}});
        directed.push_back('{32'h0001_0000, 1'b0, '0});   // exactly on the upper limit
        directed.push_back('{32'hFFFF_0000, 1'b0, '0});   // exactly on the lower limit
        directed.push_back('{32'hFFFF_E000, 1'b0, '0});   // bin edge below one half
        directed.push_back('{32'h0000_2000, 1'b0, '0});   // bin edge above one half
        directed.push_back('{32'h0000_0001, 1'b0, '0});
        directed.push_back('{32'hFFFF_FFFF, 1'b0, '0});
        foreach (directed[i])
            send_sample(directed[i].sample,
                        directed[i].typed ? directed[i].colour
                                          : false_colour(directed[i].sample));
        settle();

        // Phases: sweep palette size, limits and mode, extremes included
        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin write_reg(stc_pkg::REG_MODE, 32'd1); end
                1: begin write_reg(stc_pkg::REG_LEVELS, 9'd0);
                         write_reg(stc_pkg::REG_MODE, 32'd0); end
                2: begin write_reg(stc_pkg::REG_LEVELS, 9'd511);
                         write_reg(stc_pkg::REG_MODE, 32'd1); end
                3: begin write_reg(stc_pkg::REG_LEVELS, 9'd256);
                         write_reg(stc_pkg::REG_UPPER, 32'h7FFF_FFFF);
                         write_reg(stc_pkg::REG_LOWER, 32'h8000_0000); end
                4: begin write_reg(stc_pkg::REG_MODE, 32'd0); end
                5: begin write_reg(stc_pkg::REG_LEVELS, 9'd1);
                         write_reg(stc_pkg::REG_UPPER, 32'hFFFF_0000);   // upper below lower
                         write_reg(stc_pkg::REG_LOWER, 32'h0001_0000); end
                6: begin write_reg(stc_pkg::REG_LEVELS, 9'd2);
                         write_reg(stc_pkg::REG_UPPER, 32'd1);
                         write_reg(stc_pkg::REG_LOWER, 32'hFFFF_FFFF); end
                default:
                begin
                    write_reg(stc_pkg::REG_LEVELS, $urandom_range(511));
                    write_reg(stc_pkg::REG_UPPER,
                              $urandom_range(1) ? $urandom : $urandom_range(1 << 20));
                    write_reg(stc_pkg::REG_LOWER,
                              $urandom_range(1) ? $urandom : -$urandom_range(1 << 20));
                    write_reg(stc_pkg::REG_MODE, $urandom);
                end
            endcase
            calm = (phase == 4);
            repeat (N_RANDOM / 10)
            begin
                logic [31:0] s;
                s = rand_sample();
                send_sample(s, false_colour(s));
            end
            calm = 1'b0;
            settle();
        end

        $display("checked %0d colour beats over directed rows and ten register settings",
                 n_checked);
        $display("covering both palettes, clamped levels and both limit extremes");
        if (errors == 0 && colour_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
